// File: src/itoa_pkg.sv
package itoa_pkg;

    localparam int VALUE_WIDTH    = 32;
    localparam int IN_VALUE_WIDTH = 32;
    localparam int DEC_DIGITS     = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int HEX_DIGITS     = (VALUE_WIDTH + 3) / 4;
    localparam int BUF_DIGITS     = DEC_DIGITS;
    localparam int BUF_WIDTH      = BUF_DIGITS * 4;
    localparam int BIT_CNT_W      = $clog2(VALUE_WIDTH + 1);
    localparam int DIG_CNT_W      = $clog2(BUF_DIGITS + 1);
    localparam int DIG_IDX_W      = $clog2(BUF_DIGITS);
    localparam int CHAR_WIDTH     = 7;

    localparam logic MODE_DEC = 1'b0;
    localparam logic MODE_HEX = 1'b1;

    localparam logic [CHAR_WIDTH-1:0] DIGIT_TABLE [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
    };

    typedef struct packed {
        logic [IN_VALUE_WIDTH-1:0] value;
        logic                      mode;
    } in_t;

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] digit_char;
        logic                  last;
    } out_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic                   mode;
    } item_t;

    function automatic item_t classify(in_t req);
        logic [63:0] wide;
        item_t       item;
        wide       = 64'(req.value);
        item.value = wide[VALUE_WIDTH-1:0];
        item.mode  = req.mode;
        return item;
    endfunction

endpackage

// File: src/itoa_front.sv
module itoa_front
    import itoa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  in_t   in_data,
    output logic  q_valid,
    input  logic  q_ready,
    output item_t q_item
);

    item_t      q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= classify(in_data);
        end
    end

endmodule

// File: src/itoa_back.sv
module itoa_back
    import itoa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  q_valid,
    output logic  q_ready,
    input  item_t q_item,
    output logic  out_valid,
    input  logic  out_ready,
    output out_t  out_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0] shift_reg, shift_next;
    logic [BUF_WIDTH-1:0]   bcd_reg, bcd_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]   dig_cnt_reg, dig_cnt_next;
    logic                   started_reg, started_next;
    logic                   out_valid_reg, out_valid_next;
    out_t                   out_data_reg, out_data_next;

    logic [BUF_WIDTH-1:0]   adj;
    logic [BUF_WIDTH-1:0]   bcd_shift;
    logic [DIG_IDX_W-1:0]   dig_idx;
    logic [3:0]             cur_dig;
    logic                   slot_free;
    logic                   last_dig;

    assign q_ready   = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign slot_free = !out_valid_reg || out_ready;
    assign dig_idx   = DIG_IDX_W'(dig_cnt_reg - DIG_CNT_W'(1));
    assign cur_dig   = bcd_reg[dig_idx*4 +: 4];
    assign last_dig  = (dig_cnt_reg == DIG_CNT_W'(1));

    // add-3 step of the shift-and-add binary to bcd conversion
    always_comb
    begin
        for (int i = 0; i < BUF_DIGITS; i++)
        begin
            adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ? bcd_reg[i*4 +: 4] + 4'd3
                                                         : bcd_reg[i*4 +: 4];
        end
        bcd_shift = {adj[BUF_WIDTH-2:0], shift_reg[VALUE_WIDTH-1]};
    end

    always_comb
    begin
        state_next     = state_reg;
        shift_next     = shift_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        case (state_reg)
            ST_IDLE:
            begin
                started_next = 1'b0;
                if (q_valid)
                begin
                    if (q_item.mode == MODE_HEX)
                    begin
                        bcd_next     = BUF_WIDTH'(q_item.value);
                        dig_cnt_next = DIG_CNT_W'(HEX_DIGITS);
                        state_next   = ST_EMIT;
                    end
                    else
                    begin
                        shift_next   = q_item.value;
                        bcd_next     = '0;
                        bit_cnt_next = BIT_CNT_W'(VALUE_WIDTH);
                        state_next   = ST_CONV;
                    end
                end
            end
            ST_CONV:
            begin
                bcd_next     = bcd_shift;
                shift_next   = {shift_reg[VALUE_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_W'(1))
                begin
                    dig_cnt_next = DIG_CNT_W'(DEC_DIGITS);
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // leading zero skip
                if (!started_reg && cur_dig == 4'd0 && !last_dig)
                begin
                    dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                end
                else if (slot_free)
                begin
                    out_data_next.digit_char = DIGIT_TABLE[cur_dig];
                    out_data_next.last       = last_dig;
                    out_valid_next           = 1'b1;
                    started_next             = 1'b1;
                    dig_cnt_next             = dig_cnt_reg - DIG_CNT_W'(1);
                    if (last_dig)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg    <= shift_next;
        bcd_reg      <= bcd_next;
        out_data_reg <= out_data_next;
    end

endmodule

// File: src/integer_to_ascii_digits.sv
// integer_to_ascii_digits: unsigned integer to ascii digits, decimal or hex
//
// input channel (in_valid/in_ready/in_data): one request carries a 32-bit
// value and a mode bit, 0 decimal and 1 hexadecimal (lower-case letters).
// output channel (out_valid/out_ready/out_data): one result per digit, most
// significant first, leading zeros dropped; a zero value gives one '0'.
// out_data.last marks the final digit of a request.
// a two-entry request queue sits between the input side and the converter,
// so requests are taken while the converter works or the output stalls.
// a request passes the queue and is loaded by the idle converter; decimal
// mode then runs the shift-and-add-3 steps, and each leading zero is skipped
// before the first digit reaches the output register. the converter runs 32
// shift-and-add-3 steps in decimal mode, then steps through the digits (10
// in decimal, 8 in hex), skipping leading zeros and emitting one digit per
// cycle unless stalled; a new request loads only after the last digit.
// reset: queue empties, converter idles, out_valid drops.
// receiver stall: the output register holds its digit, the converter waits
// with its next one, and the queue keeps taking requests until it is full.
module integer_to_ascii_digits
    import itoa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    itoa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    itoa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// File: src/itoa_checker.sv
module itoa_checker
    import itoa_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input in_t  in_data,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    // waiting request holds
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("waiting request dropped or changed");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result dropped or changed");

    // nothing shown right after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

    // digits of one request follow back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last |=> out_valid)
        else $error("gap inside a digit run");

    // only legal digit characters
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.digit_char >= 7'h30 && out_data.digit_char <= 7'h39)
                   || (out_data.digit_char >= 7'h61 && out_data.digit_char <= 7'h66))
        else $error("illegal digit character");

endmodule

bind integer_to_ascii_digits itoa_checker u_itoa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
